// File: sv/vts_pkg.sv
package vts_pkg;

    localparam int MAX_NODES_DEF = 1024;
    localparam int FRAC_BITS_DEF = 24;

    localparam int VAL_W      = 32;
    localparam int MIN_DIAG_W = 31;
    localparam int STEP_W     = 10;
    localparam int ACC_W      = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int S_DATA_W   = 64;
    localparam int M_DATA_W   = 48;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LAMBDA_H = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIAG = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic row0;
        logic col_rd;
        logic col_mul;
        logic col_acc;
        logic end_sum;
        logic end_diag;
        logic end_mlo;
        logic end_mhi;
        logic end_scale;
        logic end_rhs;
        logic div_start;
        logic finish;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic row_zero;
        logic full;
        logic last;
        logic col_ok;
        logic sing;
        logic div_busy;
    } sts_t;

endpackage

// File: sv/volterra_trapezoid_stepper.sv
// Off-diagonal kernel sample: DECODE, COL_RD, COL_MUL, COL_ACC; then the next input.
// Row zero: DECODE stores f, OUT moves it to the output register, then the next transfer.
// Diagonal sample (Q8.24 by default): END_SUM to END_RHS, then the one-bit-per-cycle divider,
// then FINISH and OUT; a singular diagonal skips the divider.
// One item in flight; a waiting result sits in the output register while the next is taken.
// rst_n clears row state and lambda_h, sets min_diag to 1; the solution store has no reset.
module volterra_trapezoid_stepper #(
    parameter int MAX_NODES = vts_pkg::MAX_NODES_DEF,
    parameter int FRAC_BITS = vts_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [vts_pkg::S_DATA_W-1:0]   s_tdata,   // f_value, kernel_value
    input  logic                           s_tlast,   // row_last
    input  logic [0:0]                     s_tuser,   // restart
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [vts_pkg::M_DATA_W-1:0]   m_tdata,   // y_value, step_index, zero pad
    output logic [0:0]                     m_tuser,   // singular
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [vts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vts_pkg::VAL_W-1:0]      cfg_data
);

    vts_pkg::cmd_t cmd;
    vts_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    vts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    vts_datapath #(
        .MAX_NODES (MAX_NODES),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser[0]),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser[0])
    );

endmodule

// File: sv/vts_div.sv
module vts_div #(
    parameter int FRAC_BITS = vts_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic        busy,
    output logic [32:0] quo
);

    localparam int NB    = 64 + FRAC_BITS;
    localparam int CNT_W = $clog2(NB + 1);
    localparam logic [33:0] Q_CLAMP = 34'h1_0000_0000;

    logic [NB-1:0]    dvd_reg;
    logic [63:0]      rem_reg;
    logic [63:0]      den_reg;
    logic [32:0]      q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [64:0] trial;
    logic        ge;
    logic [63:0] rem_next;
    logic [33:0] q_wide;
    logic [32:0] q_next;

    // restoring division, one quotient bit per cycle while busy
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[NB-1]};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? 64'(trial - {1'b0, den_reg}) : trial[63:0];
        q_wide   = {q_reg, ge};
        // quotient is only needed up to saturation
        q_next   = (q_wide > Q_CLAMP) ? Q_CLAMP[32:0] : q_wide[32:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NB);
        end
        else if (busy_reg)
        begin
            cnt_reg <= CNT_W'(cnt_reg - 1'b1);
            if (cnt_reg == CNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= {num, {FRAC_BITS{1'b0}}};
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[NB-2:0], 1'b0};
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign busy = busy_reg;
    assign quo  = q_reg;

endmodule

// File: sv/vts_ctrl.sv
module vts_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    input  logic           m_tready,
    input  vts_pkg::sts_t  sts,
    output logic           s_tready,
    output logic           m_tvalid,
    output vts_pkg::cmd_t  cmd
);

    typedef enum logic [15:0] {
        ST_IDLE      = 16'b0000_0000_0000_0001,
        ST_DECODE    = 16'b0000_0000_0000_0010,
        ST_COL_RD    = 16'b0000_0000_0000_0100,
        ST_COL_MUL   = 16'b0000_0000_0000_1000,
        ST_COL_ACC   = 16'b0000_0000_0001_0000,
        ST_END_SUM   = 16'b0000_0000_0010_0000,
        ST_END_DIAG  = 16'b0000_0000_0100_0000,
        ST_END_MLO   = 16'b0000_0000_1000_0000,
        ST_END_MHI   = 16'b0000_0001_0000_0000,
        ST_END_SCALE = 16'b0000_0010_0000_0000,
        ST_END_RHS   = 16'b0000_0100_0000_0000,
        ST_DIV_GO    = 16'b0000_1000_0000_0000,
        ST_DIV_WAIT  = 16'b0001_0000_0000_0000,
        ST_FINISH    = 16'b0010_0000_0000_0000,
        ST_OUT       = 16'b0100_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.latch = s_tvalid;
                if (s_tvalid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                priority if (sts.full)
                    state_next = ST_IDLE;
                else if (sts.row_zero)
                begin
                    cmd.row0   = 1'b1;
                    state_next = ST_OUT;
                end
                else if (sts.last)
                    state_next = ST_END_SUM;
                else if (sts.col_ok)
                    state_next = ST_COL_RD;
                else
                    state_next = ST_IDLE;
            end
            ST_COL_RD:
            begin
                cmd.col_rd = 1'b1;
                state_next = ST_COL_MUL;
            end
            ST_COL_MUL:
            begin
                cmd.col_mul = 1'b1;
                state_next  = ST_COL_ACC;
            end
            ST_COL_ACC:
            begin
                cmd.col_acc = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_END_SUM:
            begin
                cmd.end_sum = 1'b1;
                state_next  = ST_END_DIAG;
            end
            ST_END_DIAG:
            begin
                cmd.end_diag = 1'b1;
                state_next   = ST_END_MLO;
            end
            ST_END_MLO:
            begin
                cmd.end_mlo = 1'b1;
                state_next  = ST_END_MHI;
            end
            ST_END_MHI:
            begin
                cmd.end_mhi = 1'b1;
                state_next  = ST_END_SCALE;
            end
            ST_END_SCALE:
            begin
                cmd.end_scale = 1'b1;
                state_next    = ST_END_RHS;
            end
            ST_END_RHS:
            begin
                cmd.end_rhs = 1'b1;
                // singular diagonal needs no division
                state_next  = sts.sing ? ST_FINISH : ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (!sts.div_busy)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                cmd.out_load = out_free;
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.out_load)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

// File: sv/vts_datapath.sv
module vts_datapath #(
    parameter int MAX_NODES = vts_pkg::MAX_NODES_DEF,
    parameter int FRAC_BITS = vts_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  vts_pkg::cmd_t                     cmd,
    output vts_pkg::sts_t                     sts,
    input  logic [vts_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic                              s_tlast,
    input  logic                              s_tuser,
    input  logic                              cfg_valid,
    input  logic [vts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vts_pkg::VAL_W-1:0]         cfg_data,
    output logic [vts_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                              m_tuser
);

    localparam int CW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int RW    = $clog2(MAX_NODES + 1);
    localparam int DW    = 66;
    localparam int VW    = vts_pkg::VAL_W;
    localparam int AW    = vts_pkg::ACC_W;
    localparam int SW    = vts_pkg::STEP_W;
    localparam int PAD_W = vts_pkg::M_DATA_W - VW - SW;

    localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};
    localparam logic signed [DW-1:0] ONE_D   = {{(DW-1){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic [32:0] Q_POS_LIM = 33'h0_7FFF_FFFF;
    localparam logic [32:0] Q_NEG_LIM = 33'h0_8000_0000;

    function automatic logic signed [AW-1:0] sat_add64(
        input logic signed [AW-1:0] a,
        input logic signed [AW-1:0] b
    );
        logic signed [AW:0] sum;
        sum = {a[AW-1], a} + {b[AW-1], b};
        if (sum[AW] != sum[AW-1])
            sat_add64 = sum[AW] ? ACC_MIN : ACC_MAX;
        else
            sat_add64 = sum[AW-1:0];
    endfunction

    // configuration
    logic signed [VW-1:0]                  lambda_h_reg;
    logic [vts_pkg::MIN_DIAG_W-1:0]        min_diag_reg;

    // item
    logic                 restart_reg;
    logic                 last_reg;
    logic signed [VW-1:0] f_reg;
    logic signed [VW-1:0] k_reg;

    // row state
    logic [RW-1:0]        row_count_reg, row_count_next;
    logic [CW-1:0]        col_count_reg, col_count_next;
    logic signed [AW-1:0] edge_reg, edge_next;
    logic signed [AW-1:0] interior_reg, interior_next;

    // solution store
    logic [VW-1:0]        store [MAX_NODES];
    logic                 mem_we;
    logic [CW-1:0]        mem_wa;
    logic [VW-1:0]        mem_wd;
    logic signed [VW-1:0] rd_y_reg;

    // shared multiplier
    logic signed [32:0]   mul_a, mul_b;
    logic signed [65:0]   mul_p;
    logic                 mul_en;
    logic signed [AW-1:0] prod_reg;

    // row end
    logic signed [AW-1:0] s_reg;
    logic [AW-1:0]        s_mag_reg;
    logic                 s_neg_reg;
    logic signed [DW-1:0] d_reg;
    logic [AW-1:0]        dmag_reg;
    logic                 d_neg_reg;
    logic                 sing_reg;
    logic [AW-1:0]        plo_reg;
    logic signed [AW-1:0] ms_reg;
    logic [AW-1:0]        rhs_mag_reg;
    logic                 rhs_neg_reg;

    // result and output
    logic [VW-1:0]        res_y_reg;
    logic [SW-1:0]        res_idx_reg;
    logic                 res_sing_reg;
    logic [VW-1:0]        out_y_reg;
    logic [SW-1:0]        out_idx_reg;
    logic                 out_sing_reg;

    logic [RW-1:0]        eff_row;
    logic                 lam_neg;
    logic [31:0]          lam_mag;
    logic signed [AW-1:0] sum_full;
    logic signed [AW-1:0] s_sh;
    logic [AW-1:0]        s_mag_calc;
    logic signed [AW-1:0] diag_sh;
    logic signed [DW-1:0] d_calc;
    logic [DW-1:0]        dmag_full;
    logic                 sing_calc;
    logic [95:0]          scale_wide;
    logic [95:0]          scale_sh;
    logic                 scale_neg;
    logic signed [AW-1:0] ms_calc;
    logic signed [AW-1:0] rhs_calc;
    logic [AW-1:0]        rhs_mag_calc;
    logic                 div_busy;
    logic [32:0]          div_quo;
    logic                 q_neg;
    logic [VW-1:0]        y_fin;

    vts_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (rhs_mag_reg),
        .den   (dmag_reg),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    assign lam_neg = lambda_h_reg[VW-1];
    assign lam_mag = lam_neg ? 32'(~lambda_h_reg + 32'sd1) : 32'(lambda_h_reg);

    // status
    assign eff_row      = restart_reg ? '0 : row_count_reg;
    assign sts.row_zero = (eff_row == '0);
    assign sts.full     = (eff_row >= RW'(MAX_NODES));
    assign sts.last     = last_reg;
    assign sts.col_ok   = (RW'(col_count_reg) < row_count_reg);
    assign sts.sing     = sing_reg;
    assign sts.div_busy = div_busy;

    // multiplier operand selection
    always_comb
    begin
        unique if (cmd.col_mul)
        begin
            mul_a = {k_reg[VW-1], k_reg};
            mul_b = {rd_y_reg[VW-1], rd_y_reg};
        end
        else if (cmd.end_sum)
        begin
            mul_a = {lambda_h_reg[VW-1], lambda_h_reg};
            mul_b = {k_reg[VW-1], k_reg};
        end
        else if (cmd.end_mlo)
        begin
            mul_a = {1'b0, s_mag_reg[31:0]};
            mul_b = {1'b0, lam_mag};
        end
        else if (cmd.end_mhi)
        begin
            mul_a = {1'b0, s_mag_reg[63:32]};
            mul_b = {1'b0, lam_mag};
        end
        else
        begin
            mul_a = '0;
            mul_b = '0;
        end
    end

    assign mul_p  = mul_a * mul_b;
    assign mul_en = cmd.col_mul || cmd.end_sum || cmd.end_mlo || cmd.end_mhi;

    // row end arithmetic
    always_comb
    begin
        sum_full   = sat_add64(edge_reg >>> 1, interior_reg);
        s_sh       = sum_full >>> FRAC_BITS;
        s_mag_calc = s_reg[AW-1] ? AW'(~s_reg + 64'sd1) : AW'(s_reg);

        diag_sh    = prod_reg >>> (FRAC_BITS + 1);
        d_calc     = ONE_D - {{(DW-AW){diag_sh[AW-1]}}, diag_sh};
        dmag_full  = d_reg[DW-1] ? DW'(~d_reg + 66'sd1) : DW'(d_reg);
        sing_calc  = (d_reg == '0) || (dmag_full < DW'(min_diag_reg));

        // prod_reg holds the high partial product here
        scale_wide = {prod_reg, 32'd0} + {32'd0, plo_reg};
        scale_sh   = scale_wide >> FRAC_BITS;
        scale_neg  = s_neg_reg ^ lam_neg;
        if (|scale_sh[95:63])
            ms_calc = scale_neg ? ACC_MIN : ACC_MAX;
        else if (scale_neg)
            ms_calc = AW'(~scale_sh[63:0] + 64'd1);
        else
            ms_calc = scale_sh[63:0];

        rhs_calc     = sat_add64({{(AW-VW){f_reg[VW-1]}}, f_reg}, ms_reg);
        rhs_mag_calc = rhs_calc[AW-1] ? AW'(~rhs_calc + 64'sd1) : AW'(rhs_calc);

        q_neg = rhs_neg_reg ^ d_neg_reg;
        priority if (sing_reg)
            y_fin = '0;
        else if (q_neg)
            y_fin = (div_quo >= Q_NEG_LIM) ? 32'h8000_0000 : 32'(~div_quo[31:0] + 32'd1);
        else
            y_fin = (div_quo > Q_POS_LIM) ? 32'h7FFF_FFFF : div_quo[31:0];
    end

    // row state update
    always_comb
    begin
        row_count_next = row_count_reg;
        col_count_next = col_count_reg;
        edge_next      = edge_reg;
        interior_next  = interior_reg;
        priority if (cmd.row0)
        begin
            row_count_next = RW'(1);
            col_count_next = '0;
            edge_next      = '0;
            interior_next  = '0;
        end
        else if (cmd.finish)
        begin
            row_count_next = RW'(row_count_reg + 1'b1);
            col_count_next = '0;
            edge_next      = '0;
            interior_next  = '0;
        end
        else if (cmd.col_acc)
        begin
            // first column takes the half weight at the end of the row
            if (col_count_reg == '0)
                edge_next = prod_reg;
            else
                interior_next = sat_add64(interior_reg, prod_reg);
            col_count_next = CW'(col_count_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lambda_h_reg  <= '0;
            min_diag_reg  <= vts_pkg::MIN_DIAG_W'(1);
            row_count_reg <= '0;
            col_count_reg <= '0;
            edge_reg      <= '0;
            interior_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    vts_pkg::REG_LAMBDA_H: lambda_h_reg <= cfg_data;
                    vts_pkg::REG_MIN_DIAG: min_diag_reg <= cfg_data[vts_pkg::MIN_DIAG_W-1:0];
                endcase
            end
            row_count_reg <= row_count_next;
            col_count_reg <= col_count_next;
            edge_reg      <= edge_next;
            interior_reg  <= interior_next;
        end
    end

    // solution store
    assign mem_we = cmd.row0 || cmd.finish;
    assign mem_wa = cmd.row0 ? '0 : row_count_reg[CW-1:0];
    assign mem_wd = cmd.row0 ? f_reg : y_fin;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store[mem_wa] <= mem_wd;
        if (cmd.col_rd)
            rd_y_reg <= store[col_count_reg];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            restart_reg <= s_tuser;
            last_reg    <= s_tlast;
            f_reg       <= s_tdata[VW-1:0];
            k_reg       <= s_tdata[2*VW-1:VW];
        end
        if (mul_en)
            prod_reg <= mul_p[AW-1:0];
        if (cmd.end_sum)
            s_reg <= s_sh;
        if (cmd.end_diag)
        begin
            d_reg     <= d_calc;
            s_mag_reg <= s_mag_calc;
            s_neg_reg <= s_reg[AW-1];
        end
        if (cmd.end_mlo)
        begin
            dmag_reg  <= dmag_full[AW-1:0];
            d_neg_reg <= d_reg[DW-1];
            sing_reg  <= sing_calc;
        end
        if (cmd.end_mhi)
            plo_reg <= prod_reg;
        if (cmd.end_scale)
            ms_reg <= ms_calc;
        if (cmd.end_rhs)
        begin
            rhs_mag_reg <= rhs_mag_calc;
            rhs_neg_reg <= rhs_calc[AW-1];
        end
        if (cmd.row0)
        begin
            res_y_reg    <= f_reg;
            res_idx_reg  <= '0;
            res_sing_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            res_y_reg    <= y_fin;
            res_idx_reg  <= SW'(row_count_reg);
            res_sing_reg <= sing_reg;
        end
        if (cmd.out_load)
        begin
            out_y_reg    <= res_y_reg;
            out_idx_reg  <= res_idx_reg;
            out_sing_reg <= res_sing_reg;
        end
    end

    assign m_tdata = {{PAD_W{1'b0}}, out_idx_reg, out_y_reg};
    assign m_tuser = out_sing_reg;

endmodule

// File: sv/vts_checker.sv
module vts_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [vts_pkg::M_DATA_W-1:0] m_tdata,
    input logic [0:0]                   m_tuser
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // singular rows carry a zero solution
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[31:0] == 32'd0)
        else $error("singular result with non-zero value");

    // one item at a time: no transfer in the cycle after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken in consecutive cycles");

endmodule

bind volterra_trapezoid_stepper vts_checker u_vts_checker (.*);
